FILE: src/bgp_pkg.sv
// ----------------------------------------------------------------------------
// bgp_pkg
// Shared types, constants and helpers for the bitmap glyph placer.
// ----------------------------------------------------------------------------
`default_nettype none

package bgp_pkg;

  // Number of character code bits that index the glyph table.
  localparam int unsigned CODE_BITS   = 16;
  localparam int unsigned TABLE_DEPTH = 1 << CODE_BITS;

  // Character code that moves the cursor to the next line.
  localparam logic [15:0] NEWLINE_CODE = 16'd10;

  // Configuration register indexes and their reset values.
  localparam logic       REG_LINE_HEIGHT     = 1'b0;
  localparam logic       REG_MISSING_ADVANCE = 1'b1;
  localparam logic [7:0] LINE_HEIGHT_RST     = 8'd48;
  localparam logic [7:0] MISSING_ADVANCE_RST = 8'd16;

  // Command carried in the input tuser field.
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2,
    CMD_CHAR  = 2'd3
  } cmd_e;

  // Input tdata, last declared field in the lowest bits.
  typedef struct packed {
    logic        [7:0]  glyph_advance;
    logic signed [7:0]  glyph_offset_y;
    logic signed [7:0]  glyph_offset_x;
    logic        [7:0]  glyph_height;
    logic        [7:0]  glyph_width;
    logic        [11:0] glyph_src_y;
    logic        [11:0] glyph_src_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_x;
    logic        [15:0] char_code;
  } in_item_t;

  // Output tdata, last declared field in the lowest bits.
  typedef struct packed {
    logic        [7:0]  draw_height;
    logic        [7:0]  draw_width;
    logic        [11:0] tex_y;
    logic        [11:0] tex_x;
    logic signed [15:0] dest_y;
    logic signed [15:0] dest_x;
  } out_item_t;

  // One glyph table entry.
  typedef struct packed {
    logic        [11:0] src_x;
    logic        [11:0] src_y;
    logic        [7:0]  width;
    logic        [7:0]  height;
    logic signed [7:0]  offset_x;
    logic signed [7:0]  offset_y;
    logic        [7:0]  advance;
  } glyph_t;

  // Status of the valid-bit clearing sweep.
  typedef struct packed {
    logic                 active;
    logic [CODE_BITS-1:0] addr;
  } sweep_t;

  // Item as it is handed to the layout stage at acceptance.
  typedef struct packed {
    cmd_e               cmd;
    logic [15:0]        char_code;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic               in_range;
    logic               nonempty;
  } stage_item_t;

  // Adds a small signed amount to a 16-bit position and clamps the result.
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [9:0]  b);
    logic signed [16:0] sum;
    sum = {a[15], a} + {{7{b[9]}}, b};
    if (sum[16] != sum[15]) begin
      return sum[16] ? 16'sh8000 : 16'sh7fff;
    end
    return sum[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/bitmap_glyph_placer.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_placer
// Lays out bitmap font glyphs as sprite rectangles from a glyph table.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: cmd; tdata: character, origin and glyph fields
//  m_axis    out        tdata: sprite position, texture position and size
//  cfg       in         write of line_height (0) or missing_advance (1)
//
// One transaction is accepted per cycle unless the sweep or a stalled output
// holds s_axis_tready low; a character's result is registered by the glyph memory read and then by the output register.
// After reset, and after each clear command, the valid-bit memory is swept
// one entry a cycle over all 2^CODE_BITS (65536) entries, while s_axis_tready is low.
// A stalled result holds the layout stage only once that stage has a result
// of its own to hand over; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_glyph_placer
  import bgp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // char_code, origin_x, origin_y, glyph_src_x, glyph_src_y, glyph_width,
  // glyph_height, glyph_offset_x, glyph_offset_y, glyph_advance
  input  wire logic [111:0] s_axis_tdata,
  // cmd
  input  wire logic [1:0]   s_axis_tuser,
  // Output stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // dest_x, dest_y, tex_x, tex_y, draw_width, draw_height
  output logic [71:0]       m_axis_tdata,
  // Configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_addr_i,
  input  wire logic [7:0]   cfg_wdata_i
);

  in_item_t             in_item;
  cmd_e                 in_cmd;
  logic                 accept, stage_ready, in_range, load_ok;
  logic [CODE_BITS-1:0] addr;
  logic [7:0]           line_height_q, missing_advance_q;
  logic                 nonempty_q;
  sweep_t               sweep;
  stage_item_t          stage_item;
  glyph_t               glyph_wdata, glyph_rdata;
  logic                 vld_we, vld_wdata, vld_rdata;
  logic [CODE_BITS-1:0] vld_addr;
  out_item_t            out_item;

  assign in_item = in_item_t'(s_axis_tdata);
  assign in_cmd  = cmd_e'(s_axis_tuser);

  // Input handshake; nothing is taken while the valid bits are being swept.
  assign s_axis_tready = stage_ready && !sweep.active;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Table address and the conditions for a load to take effect.
  assign in_range = (in_item.char_code >> CODE_BITS) == 16'd0;
  assign addr     = in_item.char_code[CODE_BITS-1:0];
  assign load_ok  = (in_cmd == CMD_LOAD) && (in_item.char_code != 16'd0) && in_range &&
                    (in_item.glyph_width != 8'd0) && (in_item.glyph_height != 8'd0);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_height_q     <= LINE_HEIGHT_RST;
      missing_advance_q <= MISSING_ADVANCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LINE_HEIGHT:     line_height_q     <= cfg_wdata_i;
        REG_MISSING_ADVANCE: missing_advance_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Flag that at least one glyph has been loaded since the last clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= 1'b0;
    end else if (accept && (in_cmd == CMD_CLEAR)) begin
      nonempty_q <= 1'b0;
    end else if (accept && load_ok) begin
      nonempty_q <= 1'b1;
    end
  end

  // Clearing sweep over the valid bits.
  bgp_clear u_clear (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && (in_cmd == CMD_CLEAR)),
    .sweep_o (sweep)
  );

  // Glyph table: written by loads, read at every accepted transaction.
  assign glyph_wdata.src_x    = in_item.glyph_src_x;
  assign glyph_wdata.src_y    = in_item.glyph_src_y;
  assign glyph_wdata.width    = in_item.glyph_width;
  assign glyph_wdata.height   = in_item.glyph_height;
  assign glyph_wdata.offset_x = in_item.glyph_offset_x;
  assign glyph_wdata.offset_y = in_item.glyph_offset_y;
  assign glyph_wdata.advance  = in_item.glyph_advance;

  bgp_ram #(
    .WIDTH ($bits(glyph_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (accept && load_ok),
    .re_i    (accept),
    .addr_i  (addr),
    .wdata_i (glyph_wdata),
    .rdata_o (glyph_rdata)
  );

  // Valid bits: the sweep writes zeros, a load sets its entry.
  assign vld_we    = sweep.active || (accept && load_ok);
  assign vld_wdata = !sweep.active;
  assign vld_addr  = sweep.active ? sweep.addr : addr;

  bgp_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_DEPTH)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .re_i    (accept),
    .addr_i  (vld_addr),
    .wdata_i (vld_wdata),
    .rdata_o (vld_rdata)
  );

  // Layout stage.
  assign stage_item.cmd       = in_cmd;
  assign stage_item.char_code = in_item.char_code;
  assign stage_item.origin_x  = in_item.origin_x;
  assign stage_item.origin_y  = in_item.origin_y;
  assign stage_item.in_range  = in_range;
  assign stage_item.nonempty  = nonempty_q;

  bgp_layout u_layout (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (accept),
    .in_item_i         (stage_item),
    .in_ready_o        (stage_ready),
    .glyph_i           (glyph_rdata),
    .glyph_valid_i     (vld_rdata),
    .line_height_i     (line_height_q),
    .missing_advance_i (missing_advance_q),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_item_o        (out_item)
  );

  assign m_axis_tdata = out_item;

endmodule

`default_nettype wire

FILE: src/bgp_ram.sv
// ----------------------------------------------------------------------------
// bgp_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bgp_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; the read data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/bgp_clear.sv
// ----------------------------------------------------------------------------
// bgp_clear
// Sweep counter that walks the valid-bit memory once to clear it.
// ----------------------------------------------------------------------------
`default_nettype none

module bgp_clear
  import bgp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output sweep_t    sweep_o
);

  logic                 active_q, active_d;
  logic [CODE_BITS-1:0] addr_q, addr_d;

  // A sweep runs after reset and after every clear command.
  always_comb begin
    active_d = active_q;
    addr_d   = addr_q;
    if (start_i) begin
      active_d = 1'b1;
      addr_d   = '0;
    end else if (active_q) begin
      addr_d = addr_q + 1'b1;
      if (addr_q == {CODE_BITS{1'b1}}) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      addr_q   <= '0;
    end else begin
      active_q <= active_d;
      addr_q   <= addr_d;
    end
  end

  assign sweep_o.active = active_q;
  assign sweep_o.addr   = addr_q;

endmodule

`default_nettype wire

FILE: src/bgp_layout.sv
// ----------------------------------------------------------------------------
// bgp_layout
// Cursor stage: moves the cursor and forms the sprite rectangle.
// ----------------------------------------------------------------------------
`default_nettype none

module bgp_layout
  import bgp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire stage_item_t in_item_i,
  output logic             in_ready_o,
  input  wire glyph_t      glyph_i,
  input  wire logic        glyph_valid_i,
  input  wire logic [7:0]  line_height_i,
  input  wire logic [7:0]  missing_advance_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o
);

  logic               s1_valid_q;
  stage_item_t        s1_q;
  logic signed [15:0] cursor_x_q, cursor_x_d;
  logic signed [15:0] cursor_y_q, cursor_y_d;
  logic signed [15:0] line_x_q, line_x_d;
  logic               out_valid_q;
  out_item_t          out_q, out_d;
  logic               is_char, is_newline, mapped, produce, out_free, s1_fire;

  // Decode the held item; the glyph memory data belongs to it.
  assign is_char    = (s1_q.cmd == CMD_CHAR) && s1_q.nonempty;
  assign is_newline = s1_q.char_code == NEWLINE_CODE;
  assign mapped     = s1_q.in_range && glyph_valid_i;
  assign produce    = s1_valid_q && is_char && !is_newline && mapped;

  // The stage moves on unless its result finds the output register full.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!produce || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  // Cursor update and result formation.
  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    line_x_d   = line_x_q;
    out_d.dest_x      = sat_add(cursor_x_q, {{2{glyph_i.offset_x[7]}}, glyph_i.offset_x});
    out_d.dest_y      = sat_add(cursor_y_q, {{2{glyph_i.offset_y[7]}}, glyph_i.offset_y});
    out_d.tex_x       = glyph_i.src_x;
    out_d.tex_y       = glyph_i.src_y;
    out_d.draw_width  = glyph_i.width;
    out_d.draw_height = glyph_i.height;
    if (s1_q.cmd == CMD_START) begin
      cursor_x_d = s1_q.origin_x;
      cursor_y_d = s1_q.origin_y;
      line_x_d   = s1_q.origin_x;
    end else if (is_char) begin
      if (is_newline) begin
        cursor_x_d = line_x_q;
        cursor_y_d = sat_add(cursor_y_q, {2'b00, line_height_i});
      end else if (!mapped) begin
        cursor_x_d = sat_add(cursor_x_q, {2'b00, missing_advance_i});
      end else begin
        cursor_x_d = sat_add(cursor_x_q, {2'b00, glyph_i.advance});
      end
    end
  end

  // Stage and cursor registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      line_x_q   <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        cursor_x_q <= cursor_x_d;
        cursor_y_q <= cursor_y_d;
        line_x_q   <= line_x_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_item_i;
    end
  end

  // Output register decouples the result from the next item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (produce && s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce && s1_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: dv/bitmap_glyph_placer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_glyph_placer_tb
// Self-checking regression for the bitmap glyph placer. A queue of text
// commands feeds a clocked stream driver, and a clocked monitor takes the
// sprite results. A predictor with its own glyph table, cursor and register
// copies works out each sprite when its command is accepted, and the monitor
// compares every result field by field with the oldest prediction. A short
// directed part covers the special cases, then several register settings are
// run with random text built around a loaded font.
// ----------------------------------------------------------------------------

module bitmap_glyph_placer_tb;
  import bgp_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 90;
  localparam int PHASES        = 6;
  localparam int LONG_HOLD_AT  = 60;
  localparam int LONG_HOLD_LEN = 500;

  // One command as it travels on the input stream.
  typedef struct packed {
    cmd_e     cmd;
    in_item_t data;
  } text_op_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = CMD_CLEAR;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic         cfg_we_i      = 1'b0;
  logic         cfg_addr_i    = REG_LINE_HEIGHT;
  logic [7:0]   cfg_wdata_i   = '0;

  bitmap_glyph_placer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predicted layout state: the font table holds only valid entries.
  glyph_t    font_table [int];
  int        pen_x, pen_y, line_origin_x;
  int        line_gap     = LINE_HEIGHT_RST;
  int        missing_step = MISSING_ADVANCE_RST;

  text_op_t  pending_ops [$];
  out_item_t expected_sprites [$];
  int        font_codes [8];

  int        fail_count  = 0;
  int        cycle_count = 0;

  // Driver and monitor bookkeeping.
  text_op_t  drv_op;
  bit        op_in_flight   = 1'b0;
  int        drv_gap_left   = 0;
  int        drv_quiet_left = 0;
  int        mon_hold_left  = 0;
  int        mon_quiet_left = 0;
  int        sprites_seen   = 0;

  // Adds two pixel amounts and clamps the sum to the signed 16-bit range.
  function automatic int clamp_sum(int a, int b);
    int s;
    s = a + b;
    if (s > 32767) return 32767;
    if (s < -32768) return -32768;
    return s;
  endfunction

  // Draws a random wait, with occasional stretches of no waiting.
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(16, 48);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Updates the predicted state for one accepted command and queues its sprite.
  task automatic place_text_item(input text_op_t op);
    glyph_t    g;
    out_item_t spr;
    int        code;
    code = op.data.char_code;
    case (op.cmd)
      CMD_CLEAR: begin
        font_table.delete();
      end
      CMD_LOAD: begin
        if (code != 0 && op.data.glyph_width != 0 && op.data.glyph_height != 0) begin
          g.src_x    = op.data.glyph_src_x;
          g.src_y    = op.data.glyph_src_y;
          g.width    = op.data.glyph_width;
          g.height   = op.data.glyph_height;
          g.offset_x = op.data.glyph_offset_x;
          g.offset_y = op.data.glyph_offset_y;
          g.advance  = op.data.glyph_advance;
          font_table[code] = g;
        end
      end
      CMD_START: begin
        pen_x         = int'($signed(op.data.origin_x));
        pen_y         = int'($signed(op.data.origin_y));
        line_origin_x = pen_x;
      end
      default: begin
        // Characters have no effect at all while the table is empty.
        if (font_table.num() != 0) begin
          if (code == int'(NEWLINE_CODE)) begin
            pen_x = line_origin_x;
            pen_y = clamp_sum(pen_y, line_gap);
          end else if (!font_table.exists(code)) begin
            pen_x = clamp_sum(pen_x, missing_step);
          end else begin
            g           = font_table[code];
            spr.dest_x  = 16'(clamp_sum(pen_x, int'($signed(g.offset_x))));
            spr.dest_y  = 16'(clamp_sum(pen_y, int'($signed(g.offset_y))));
            spr.tex_x   = g.src_x;
            spr.tex_y   = g.src_y;
            spr.draw_width  = g.width;
            spr.draw_height = g.height;
            expected_sprites.push_back(spr);
            pen_x = clamp_sum(pen_x, int'(g.advance));
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Command builders; unused fields stay zero.
  function automatic text_op_t load_op(int code, int sx, int sy, int w, int h,
                                       int ox, int oy, int adv);
    text_op_t op;
    op                     = '0;
    op.cmd                 = CMD_LOAD;
    op.data.char_code      = 16'(code);
    op.data.glyph_src_x    = 12'(sx);
    op.data.glyph_src_y    = 12'(sy);
    op.data.glyph_width    = 8'(w);
    op.data.glyph_height   = 8'(h);
    op.data.glyph_offset_x = 8'(ox);
    op.data.glyph_offset_y = 8'(oy);
    op.data.glyph_advance  = 8'(adv);
    return op;
  endfunction

  function automatic text_op_t start_op(int x, int y);
    text_op_t op;
    op               = '0;
    op.cmd           = CMD_START;
    op.data.origin_x = 16'(x);
    op.data.origin_y = 16'(y);
    return op;
  endfunction

  function automatic text_op_t char_op(int code);
    text_op_t op;
    op                = '0;
    op.cmd            = CMD_CHAR;
    op.data.char_code = 16'(code);
    return op;
  endfunction

  function automatic text_op_t clear_op();
    text_op_t op;
    op     = '0;
    op.cmd = CMD_CLEAR;
    return op;
  endfunction

  // Mostly codes of the current font, with newline, code zero and noise mixed in.
  function automatic int pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return font_codes[$urandom_range(0, 7)];
    if (r < 71) return int'(NEWLINE_CODE);
    if (r < 75) return 0;
    return $urandom_range(0, 65535);
  endfunction

  function automatic int pick_origin();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return 32767 - $urandom_range(0, 300);
      3: return -32768 + $urandom_range(0, 300);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // A random command with every field filled, so that ignored fields toggle too.
  function automatic text_op_t random_op();
    text_op_t op;
    int       r;
    op.data.char_code      = 16'($urandom);
    op.data.origin_x       = 16'($urandom);
    op.data.origin_y       = 16'($urandom);
    op.data.glyph_src_x    = 12'($urandom);
    op.data.glyph_src_y    = 12'($urandom);
    op.data.glyph_width    = 8'($urandom);
    op.data.glyph_height   = 8'($urandom);
    op.data.glyph_offset_x = 8'($urandom);
    op.data.glyph_offset_y = 8'($urandom);
    op.data.glyph_advance  = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 18) begin
      op.cmd            = CMD_LOAD;
      op.data.char_code = 16'(pick_code());
      case ($urandom_range(0, 9))
        0: op.data.glyph_width  = 8'd0;
        1: op.data.glyph_height = 8'd0;
        default: ;
      endcase
    end else if (r < 26) begin
      op.cmd           = CMD_START;
      op.data.origin_x = 16'(pick_origin());
      op.data.origin_y = 16'(pick_origin());
    end else begin
      op.cmd            = CMD_CHAR;
      op.data.char_code = 16'(pick_code());
    end
    return op;
  endfunction

  task automatic write_reg(input logic addr, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    if (addr == REG_LINE_HEIGHT) line_gap = value;
    else missing_step = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Holds the sender back until every command is taken and every sprite seen,
  // then lets the pipeline settle.
  task automatic wait_idle();
    while (pending_ops.size() != 0 || op_in_flight || expected_sprites.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Input stream driver: presents queued commands with a random gap after each.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        place_text_item(drv_op);
        op_in_flight = 1'b0;
      end
      if (!op_in_flight) begin
        if (drv_gap_left > 0) begin
          drv_gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          drv_op        = pending_ops.pop_front();
          op_in_flight  = 1'b1;
          s_axis_tdata  <= drv_op.data;
          s_axis_tuser  <= drv_op.cmd;
          s_axis_tvalid <= 1'b1;
          drv_gap_left  = draw_wait(drv_quiet_left);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each sprite transaction and stalls at random, once
  // for a long stretch so that the block backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_sprites.size() == 0) begin
          $error("sprite result with none expected: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_sprites.pop_front();
          check_field("dest_x", $signed(want.dest_x), $signed(got.dest_x));
          check_field("dest_y", $signed(want.dest_y), $signed(got.dest_y));
          check_field("tex_x", want.tex_x, got.tex_x);
          check_field("tex_y", want.tex_y, got.tex_y);
          check_field("draw_width", want.draw_width, got.draw_width);
          check_field("draw_height", want.draw_height, got.draw_height);
        end
        sprites_seen++;
        mon_hold_left = (sprites_seen == LONG_HOLD_AT) ? LONG_HOLD_LEN
                                                       : draw_wait(mon_quiet_left);
      end
      if (mon_hold_left > 0) begin
        mon_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_glyph_placer regression: fail");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int phase;
    int n;
    int clear_at;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, run with the reset register values.
    pending_ops.push_back(char_op(65));
    pending_ops.push_back(char_op(NEWLINE_CODE));
    pending_ops.push_back(start_op(100, 200));
    pending_ops.push_back(load_op(0, 5, 5, 5, 5, 1, 1, 5));
    pending_ops.push_back(load_op(65, 1, 1, 0, 5, 1, 1, 5));
    pending_ops.push_back(load_op(65, 1, 1, 5, 0, 1, 1, 5));
    pending_ops.push_back(char_op(65));
    pending_ops.push_back(load_op(65, 4095, 4095, 255, 255, -128, 127, 255));
    pending_ops.push_back(load_op(65535, 0, 0, 1, 1, 127, -128, 0));
    pending_ops.push_back(load_op(66, 1, 2, 3, 4, 0, 0, 7));
    pending_ops.push_back(load_op(66, 100, 200, 9, 9, -1, -1, 9));
    pending_ops.push_back(load_op(NEWLINE_CODE, 7, 7, 7, 7, 7, 7, 7));
    pending_ops.push_back(char_op(65));
    pending_ops.push_back(char_op(66));
    pending_ops.push_back(char_op(0));
    pending_ops.push_back(char_op(1234));
    pending_ops.push_back(char_op(NEWLINE_CODE));
    pending_ops.push_back(char_op(65535));
    pending_ops.push_back(start_op(32757, -32768));
    pending_ops.push_back(char_op(65));
    pending_ops.push_back(char_op(65535));
    pending_ops.push_back(char_op(1));
    pending_ops.push_back(start_op(-32768, 32767));
    pending_ops.push_back(char_op(NEWLINE_CODE));
    pending_ops.push_back(char_op(65));
    pending_ops.push_back(clear_op());
    pending_ops.push_back(char_op(65));
    pending_ops.push_back(start_op(5, 5));

    // Random phases, each with its own register setting and font.
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(REG_LINE_HEIGHT, 8'd0);
          write_reg(REG_MISSING_ADVANCE, 8'd255);
        end
        1: begin
          write_reg(REG_LINE_HEIGHT, 8'd255);
          write_reg(REG_MISSING_ADVANCE, 8'd0);
        end
        default: begin
          write_reg(REG_LINE_HEIGHT, 8'($urandom));
          write_reg(REG_MISSING_ADVANCE, 8'($urandom));
        end
      endcase

      font_codes[0] = 65535;
      font_codes[1] = 1;
      for (n = 2; n < 8; n++) font_codes[n] = $urandom_range(2, 65534);
      for (n = 0; n < 8; n++) begin
        pending_ops.push_back(load_op(font_codes[n], $urandom_range(0, 4095),
                                      $urandom_range(0, 4095), $urandom_range(1, 255),
                                      $urandom_range(1, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 255), $urandom_range(0, 255)));
      end
      pending_ops.push_back(start_op(pick_origin(), pick_origin()));

      // Clears are costly, since each one starts a sweep of the whole table.
      clear_at = (phase == 1 || phase == 3 || phase == 4) ? $urandom_range(10, 80) : -1;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
        if (n == clear_at) pending_ops.push_back(clear_op());
        pending_ops.push_back(random_op());
      end
    end

    wait_idle();
    if (fail_count == 0 && expected_sprites.size() == 0) begin
      $display("bitmap_glyph_placer regression: pass");
    end else begin
      $display("bitmap_glyph_placer regression: fail");
    end
    $finish;
  end

endmodule
